// File: sv/tlru_pkg.sv
// Shared types and constants for the two-way LRU cache tag lookup.
package tlru_pkg;

    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic
    {
        WAY0 = 1'b0,
        WAY1 = 1'b1
    } way_t;

endpackage

// File: sv/two_way_lru_cache_tag_lookup.sv
// Tag store of a two-way set-associative cache with LRU replacement.
//
// Request channel: req_valid / req_stall carry one byte address. A request
// is taken when req_valid is high and req_stall is low.
// Response channel: rsp_valid / rsp_stall carry one result per request:
// byte offset, line number, set, tag, way used, miss flag, eviction info,
// and running hit and miss counts (32 bits, wrapping).
// NUM_SETS must be a power of two.
//
// Operation: the tags and LRU bit of a set sit in one synchronous RAM,
// read into a register. A request reads the set when it is taken; in
// ST_LOOKUP the lookup compares, then writes back and loads the result
// register once that register is free. A new request waits until the
// write back to the same RAM is done; rsp_valid rises when the result
// register is loaded.
// A result waiting in the output register does not block the next request
// from being taken; it blocks only that request's write back.
// Reset clears the valid bits and both counters at once; the tag RAM
// needs no clearing, since entries are only read behind a valid bit.
// While rsp_stall holds a result, the result stays put and the lookup
// behind it waits without touching the cache state.
module two_way_lru_cache_tag_lookup
#(
    parameter int NUM_SETS    = 64,
    parameter int OFFSET_BITS = 5
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_stall,
    input  tlru_pkg::addr_t                         address,
    output logic                                    rsp_valid,
    input  logic                                    rsp_stall,
    output logic [OFFSET_BITS-1:0]                  byte_offset,
    output logic [tlru_pkg::ADDR_W-OFFSET_BITS-1:0] line_number,
    output logic [$clog2(NUM_SETS)-1:0]             set_index,
    output logic                                    way_used,
    output logic [tlru_pkg::ADDR_W-OFFSET_BITS-$clog2(NUM_SETS)-1:0] tag_value,
    output logic                                    is_miss,
    output logic                                    replaced_valid,
    output logic [tlru_pkg::ADDR_W-OFFSET_BITS-$clog2(NUM_SETS)-1:0] evicted_tag,
    output tlru_pkg::count_t                        hits_so_far,
    output tlru_pkg::count_t                        misses_so_far
);

    import tlru_pkg::*;

    localparam int SET_BITS = $clog2(NUM_SETS);
    localparam int LINE_W   = ADDR_W - OFFSET_BITS;
    localparam int TAG_W    = LINE_W - SET_BITS;

    typedef logic [SET_BITS-1:0] set_t;
    typedef logic [TAG_W-1:0]    tag_t;

    // RAM entry: most recently used way, then the tags of way 1 and way 0
    typedef struct packed
    {
        way_t recent;
        tag_t tag1;
        tag_t tag0;
    } entry_t;

    typedef enum logic
    {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg;

    entry_t tag_mem [NUM_SETS];
    entry_t rd_entry_reg;

    logic [1:0] valid_reg [NUM_SETS];

    addr_t  addr_reg;
    count_t hit_cnt_reg;
    count_t miss_cnt_reg;

    logic                rsp_valid_reg;
    logic [OFFSET_BITS-1:0] byte_offset_reg;
    logic [LINE_W-1:0]   line_number_reg;
    set_t                set_index_reg;
    way_t                way_used_reg;
    tag_t                tag_value_reg;
    logic                is_miss_reg;
    logic                replaced_valid_reg;
    tag_t                evicted_tag_reg;

    logic   req_take;
    set_t   req_set;
    set_t   cur_set;
    tag_t   cur_tag;
    logic [1:0] cur_valid;
    way_t   cur_recent;
    logic   hit0;
    logic   hit1;
    logic   miss;
    way_t   way_sel;
    logic   repl;
    tag_t   evict;
    logic   complete;
    entry_t wr_entry;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign req_set   = address[OFFSET_BITS +: SET_BITS];

    assign cur_set   = addr_reg[OFFSET_BITS +: SET_BITS];
    assign cur_tag   = addr_reg[ADDR_W-1 -: TAG_W];
    assign cur_valid = valid_reg[cur_set];

    // a set never touched reads as way 1 most recent
    assign cur_recent = (cur_valid == 2'b00) ? WAY1 : rd_entry_reg.recent;

    assign hit0 = cur_valid[0] && (rd_entry_reg.tag0 == cur_tag);
    assign hit1 = cur_valid[1] && (rd_entry_reg.tag1 == cur_tag);
    assign miss = !hit0 && !hit1;

    always_comb
    begin
        if (miss)
        begin
            way_sel = (cur_recent == WAY1) ? WAY0 : WAY1;
        end
        else
        begin
            way_sel = hit1 ? WAY1 : WAY0;
        end
    end

    assign repl  = miss && cur_valid[way_sel];
    assign evict = !repl ? '0 : ((way_sel == WAY1) ? rd_entry_reg.tag1 : rd_entry_reg.tag0);

    // write back only once the result register can take the result
    assign complete = (state_reg == ST_LOOKUP) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        wr_entry        = rd_entry_reg;
        wr_entry.recent = way_sel;
        if (way_sel == WAY1)
        begin
            wr_entry.tag1 = cur_tag;
        end
        else
        begin
            wr_entry.tag0 = cur_tag;
        end
    end

    // tag RAM: read on request, write back on completion, never both at once
    always_ff @(posedge clk)
    begin
        if (complete)
        begin
            tag_mem[cur_set] <= wr_entry;
        end
        if (req_take)
        begin
            rd_entry_reg <= tag_mem[req_set];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            addr_reg <= address;
        end
        if (complete)
        begin
            byte_offset_reg    <= addr_reg[OFFSET_BITS-1:0];
            line_number_reg    <= addr_reg[ADDR_W-1:OFFSET_BITS];
            set_index_reg      <= cur_set;
            way_used_reg       <= way_sel;
            tag_value_reg      <= cur_tag;
            is_miss_reg        <= miss;
            replaced_valid_reg <= repl;
            evicted_tag_reg    <= evict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            for (int i = 0; i < NUM_SETS; i++)
            begin
                valid_reg[i] <= 2'b00;
            end
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && !complete)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_take)
                    begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    if (complete)
                    begin
                        state_reg     <= ST_IDLE;
                        rsp_valid_reg <= 1'b1;
                        valid_reg[cur_set][way_sel] <= 1'b1;
                        if (miss)
                        begin
                            miss_cnt_reg <= miss_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            hit_cnt_reg <= hit_cnt_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign byte_offset    = byte_offset_reg;
    assign line_number    = line_number_reg;
    assign set_index      = set_index_reg;
    assign way_used       = way_used_reg;
    assign tag_value      = tag_value_reg;
    assign is_miss        = is_miss_reg;
    assign replaced_valid = replaced_valid_reg;
    assign evicted_tag    = evicted_tag_reg;
    assign hits_so_far    = hit_cnt_reg;
    assign misses_so_far  = miss_cnt_reg;

    // a fill only happens on a miss, so both ways can never match
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) |-> !(hit0 && hit1))
    else $error("tag matches in both ways of a set");

    // each completed request bumps exactly one counter
    assert property (@(posedge clk) disable iff (!rst_n)
        complete |=> (hit_cnt_reg + miss_cnt_reg) ==
                     ($past(hit_cnt_reg) + $past(miss_cnt_reg) + 1'b1))
    else $error("hit/miss counters out of step");

    // the used way is valid after write back
    assert property (@(posedge clk) disable iff (!rst_n)
        complete |=> valid_reg[$past(cur_set)][$past(way_sel)])
    else $error("used way not marked valid");

    // a hit never reports an eviction
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !is_miss_reg) |-> (!replaced_valid_reg && evicted_tag_reg == '0))
    else $error("eviction reported on a hit");

    // no write back while a result is still stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !complete)
    else $error("result register overwritten while stalled");

endmodule
